@@ hdl/tlj_pkg.sv @@
// ----------------------------------------------------------------------------
// tlj_pkg: shared constants and types of the text line justifier
// Line geometry, character ring size, queue entry and controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package tlj_pkg;

  // widest line in characters
  localparam int unsigned WIDTH_LIMIT = 32;
  // most words a line can hold
  localparam int unsigned MAX_WORDS = WIDTH_LIMIT / 2;
  // character ring holds the pending line plus the current word
  localparam int unsigned RING_DEPTH = 2 * WIDTH_LIMIT;
  localparam int unsigned RING_AW = $clog2(RING_DEPTH);
  localparam int unsigned WIDTH_W = $clog2(WIDTH_LIMIT + 1);
  localparam int unsigned IDX_W = $clog2(WIDTH_LIMIT);
  localparam int unsigned WORD_AW = $clog2(MAX_WORDS);
  localparam int unsigned CNT_W = $clog2(MAX_WORDS + 1);
  localparam int unsigned DIV_STEPS = WIDTH_W;

  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(WIDTH_LIMIT);

  // classified input item as queued between front and back
  typedef struct packed {
    logic [7:0]         ch;
    logic               keep;       // character is stored
    logic [IDX_W-1:0]   idx;        // position within the current word
    logic               word_done;  // word completes with this item
    logic               text_done;  // text completes with this item
    logic [WIDTH_W-1:0] len;        // kept word length, cut at the width
  } q_entry_t;

  // line controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ADD,
    ST_SETUP,
    ST_DIV,
    ST_EMIT
  } back_state_t;

  // what the emitter is walking over
  typedef enum logic [1:0] {
    PH_WORD,
    PH_GAP,
    PH_PAD
  } emit_phase_t;

endpackage

`default_nettype wire

@@ hdl/tlj_if.sv @@
// ----------------------------------------------------------------------------
// tlj_if: channel interfaces of the text line justifier
// Input character channel, output line channel and width register channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface tlj_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       word_end;
  logic       text_end;
  modport source (output valid, text_char, word_end, text_end, input ready);
  modport sink   (input valid, text_char, word_end, text_end, output ready);
endinterface

interface tlj_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       line_last;
  logic       run_last;
  modport source (output valid, out_char, line_last, run_last, input ready);
  modport sink   (input valid, out_char, line_last, run_last, output ready);
endinterface

interface tlj_cfg_if;
  logic       valid;
  logic       ready;
  logic [5:0] line_width;
  modport source (output valid, line_width, input ready);
  modport sink   (input valid, line_width, output ready);
endinterface

`default_nettype wire

@@ hdl/tlj_queue.sv @@
// ----------------------------------------------------------------------------
// tlj_queue: two-entry queue between front and back
// Lets the classifier and the line controller stall independently.
// ----------------------------------------------------------------------------
`default_nettype none

module tlj_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire tlj_pkg::q_entry_t push_data,
  output logic                   full,
  input  wire logic              pop,
  output logic                   avail,
  output tlj_pkg::q_entry_t      head
);

  tlj_pkg::q_entry_t slots [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        fill;

  assign full  = (fill == 2'd2);
  assign avail = (fill != 2'd0);
  assign head  = slots[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

endmodule

`default_nettype wire

@@ hdl/tlj_front.sv @@
// ----------------------------------------------------------------------------
// tlj_front: input classifier
// Tracks the current word length, marks kept characters and word ends.
// ----------------------------------------------------------------------------
`default_nettype none

module tlj_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [tlj_pkg::WIDTH_W-1:0]   width,
  tlj_in_if.sink                             text_in,
  input  wire logic                          q_full,
  output logic                               q_push,
  output tlj_pkg::q_entry_t                  q_data
);

  logic [tlj_pkg::WIDTH_W-1:0] word_len;
  logic [tlj_pkg::WIDTH_W-1:0] word_len_next;
  logic                        keep;
  logic                        done;
  logic [tlj_pkg::WIDTH_W-1:0] kept_len;

  assign text_in.ready = ~q_full;
  assign q_push        = text_in.valid & ~q_full;

  // classify the item
  assign keep     = (word_len < width);
  assign done     = text_in.word_end | text_in.text_end;
  assign kept_len = keep ? word_len + tlj_pkg::WIDTH_W'(1) : word_len;

  always_comb begin
    q_data.ch        = text_in.text_char;
    q_data.keep      = keep;
    q_data.idx       = word_len[tlj_pkg::IDX_W-1:0];
    q_data.word_done = done;
    q_data.text_done = text_in.text_end;
    q_data.len       = (kept_len > width) ? width : kept_len;
  end

  // current word length
  always_comb begin
    word_len_next = word_len;
    if (q_push) begin
      if (done) word_len_next = '0;
      else      word_len_next = kept_len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) word_len <= '0;
    else     word_len <= word_len_next;
  end

endmodule

`default_nettype wire

@@ hdl/tlj_back.sv @@
// ----------------------------------------------------------------------------
// tlj_back: line controller
// Stores characters in a ring, packs words into lines and emits each line
// one character per cycle while line_out is ready, with gap sizes from a bit-serial divider.
// ----------------------------------------------------------------------------
`default_nettype none

module tlj_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [tlj_pkg::WIDTH_W-1:0]   width,
  input  wire logic                          q_avail,
  input  wire tlj_pkg::q_entry_t             q_head,
  output logic                               q_pop,
  tlj_out_if.source                          line_out
);

  localparam int unsigned WW = tlj_pkg::WIDTH_W;
  localparam int unsigned AW = tlj_pkg::RING_AW;
  localparam int unsigned KW = tlj_pkg::WORD_AW;
  localparam int unsigned CW = tlj_pkg::CNT_W;
  localparam int unsigned SW = $clog2(tlj_pkg::DIV_STEPS);

  tlj_pkg::back_state_t state, state_next;
  tlj_pkg::emit_phase_t phase;

  // character ring
  logic [7:0]    ring [tlj_pkg::RING_DEPTH];
  logic [7:0]    rdata;
  logic [AW-1:0] waddr;
  logic [AW-1:0] rd_ptr, rd_ptr_next;
  logic          mem_we;

  // pending line
  logic [AW-1:0] base;
  logic [WW-1:0] chars;
  logic [CW-1:0] cnt;
  logic [WW-1:0] wlens [tlj_pkg::MAX_WORDS];
  logic [WW-1:0] cur_len;
  logic          cur_tend;
  logic          emit_full;

  // emitter
  logic [WW-1:0] each;
  logic [KW-1:0] extra;
  logic [WW-1:0] pos;
  logic [KW-1:0] k;
  logic [WW-1:0] i;
  logic [WW-1:0] gap;
  logic [WW:0]   i_inc;

  // divider
  logic [KW-1:0] rem;
  logic [WW-1:0] quo;
  logic [WW-1:0] dvd;
  logic [KW-1:0] dsr;
  logic [SW-1:0] dcnt;
  logic [KW:0]   trial;
  logic          ge;
  logic [KW-1:0] rem_new;

  // output register
  logic       ov;
  logic [7:0] oc;
  logic       ol;
  logic       orun;

  logic        emit_go;
  logic        emit_step;
  logic        last_pos;
  logic        overflow;
  logic        do_div;
  logic [WW:0] line_need;
  logic [WW:0] packed_len;

  assign line_out.valid     = ov;
  assign line_out.out_char  = oc;
  assign line_out.line_last = ol;
  assign line_out.run_last  = orun;

  // line fit and justification checks
  assign line_need  = (WW+1)'(chars) + (WW+1)'(cnt) + (WW+1)'(cur_len);
  assign overflow   = (cnt != '0) && (line_need > (WW+1)'(width));
  assign packed_len = (WW+1)'(chars) + (WW+1)'(cnt) - (WW+1)'(1);
  assign do_div     = emit_full && (cnt > CW'(1)) && (packed_len <= (WW+1)'(width));

  assign emit_go  = ~ov | line_out.ready;
  assign last_pos = (pos == width - WW'(1));
  assign i_inc    = (WW+1)'(i) + (WW+1)'(1);

  // restoring divider step
  assign trial   = {rem, dvd[WW-1]};
  assign ge      = (trial >= (KW+1)'(dsr));
  assign rem_new = ge ? KW'(trial - (KW+1)'(dsr)) : trial[KW-1:0];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      tlj_pkg::ST_IDLE:  if (q_avail && q_head.word_done) state_next = tlj_pkg::ST_CHECK;
      tlj_pkg::ST_CHECK: state_next = overflow ? tlj_pkg::ST_SETUP : tlj_pkg::ST_ADD;
      tlj_pkg::ST_ADD:   state_next = cur_tend ? tlj_pkg::ST_SETUP : tlj_pkg::ST_IDLE;
      tlj_pkg::ST_SETUP: state_next = do_div ? tlj_pkg::ST_DIV : tlj_pkg::ST_EMIT;
      tlj_pkg::ST_DIV: begin
        if (dcnt == SW'(tlj_pkg::DIV_STEPS - 1)) state_next = tlj_pkg::ST_EMIT;
      end
      tlj_pkg::ST_EMIT: begin
        if (emit_go && last_pos) begin
          state_next = emit_full ? tlj_pkg::ST_ADD : tlj_pkg::ST_IDLE;
        end
      end
      default: state_next = tlj_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    q_pop     = (state == tlj_pkg::ST_IDLE) && q_avail;
    mem_we    = q_pop && q_head.keep;
    emit_step = (state == tlj_pkg::ST_EMIT) && emit_go;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= tlj_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // ring addressing, read data always follows rd_ptr
  assign waddr = base + AW'(chars) + AW'(q_head.idx);

  always_comb begin
    if (state != tlj_pkg::ST_EMIT)           rd_ptr_next = base;
    else if (emit_step && phase == tlj_pkg::PH_WORD) rd_ptr_next = rd_ptr + AW'(1);
    else                                     rd_ptr_next = rd_ptr;
  end

  always_ff @(posedge clk) begin
    if (mem_we) ring[waddr] <= q_head.ch;
    rdata <= ring[rd_ptr_next];
  end

  // line bookkeeping and control
  always_ff @(posedge clk) begin
    if (rst) begin
      base   <= '0;
      chars  <= '0;
      cnt    <= '0;
      rd_ptr <= '0;
      ov     <= 1'b0;
    end else begin
      rd_ptr <= rd_ptr_next;
      if (state == tlj_pkg::ST_ADD) begin
        cnt   <= cnt + CW'(1);
        chars <= chars + cur_len;
      end
      if (emit_step) begin
        ov <= 1'b1;
        if (last_pos) begin
          base  <= base + AW'(chars);
          chars <= '0;
          cnt   <= '0;
        end
      end else if (line_out.ready) begin
        ov <= 1'b0;
      end
    end
  end

  // word, divider and emitter datapath
  always_ff @(posedge clk) begin
    case (state)
      tlj_pkg::ST_IDLE: begin
        if (q_pop && q_head.word_done) begin
          cur_len  <= q_head.len;
          cur_tend <= q_head.text_done;
        end
      end
      tlj_pkg::ST_CHECK: emit_full <= overflow;
      tlj_pkg::ST_ADD: begin
        wlens[cnt[KW-1:0]] <= cur_len;
        emit_full          <= 1'b0;
      end
      tlj_pkg::ST_SETUP: begin
        each  <= WW'(1);
        extra <= '0;
        pos   <= '0;
        k     <= '0;
        i     <= '0;
        phase <= tlj_pkg::PH_WORD;
        rem   <= '0;
        quo   <= '0;
        dvd   <= width - chars;
        dsr   <= KW'(cnt - CW'(1));
        dcnt  <= '0;
      end
      tlj_pkg::ST_DIV: begin
        rem  <= rem_new;
        quo  <= {quo[WW-2:0], ge};
        dvd  <= {dvd[WW-2:0], 1'b0};
        dcnt <= dcnt + SW'(1);
        if (dcnt == SW'(tlj_pkg::DIV_STEPS - 1)) begin
          each  <= {quo[WW-2:0], ge};
          extra <= rem_new;
        end
      end
      tlj_pkg::ST_EMIT: begin
        if (emit_step) begin
          oc   <= (phase == tlj_pkg::PH_WORD) ? rdata : tlj_pkg::SPACE_CHAR;
          ol   <= last_pos;
          orun <= last_pos && !(emit_full && cur_tend);
          pos  <= pos + WW'(1);
          case (phase)
            tlj_pkg::PH_WORD: begin
              if (i_inc == (WW+1)'(wlens[k])) begin
                i <= '0;
                if ((CW'(k) + CW'(1)) == cnt) begin
                  phase <= tlj_pkg::PH_PAD;
                end else begin
                  phase <= tlj_pkg::PH_GAP;
                  gap   <= each + WW'(k < extra);
                  k     <= k + KW'(1);
                end
              end else begin
                i <= i_inc[WW-1:0];
              end
            end
            tlj_pkg::PH_GAP: begin
              if (gap == WW'(1)) phase <= tlj_pkg::PH_WORD;
              else               gap   <= gap - WW'(1);
            end
            default: phase <= phase;
          endcase
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/text_line_justifier.sv @@
// ----------------------------------------------------------------------------
// text_line_justifier: greedy full text justification
// Packs a character stream into lines of a set width and emits them justified.
// ----------------------------------------------------------------------------
// Usage:
//   text_in  carries one word character per transfer, word_end on the last
//            character of a word and text_end on the last of the text.
//   line_out carries the lines, one character per transfer, line_last on each
//            line end, run_last on the last character caused by one input.
//   cfg      writes line_width (0 acts as 1, above 32 acts as 32); ready is
//            always high. Write it only while the block is idle.
// Timing: a word character is taken in the IDLE state of the line controller,
//   a word end runs through CHECK and ADD; each emitted line adds a setup
//   state, a bit-serial division when gaps are shared out and one character
//   per cycle while line_out is ready.
// Reset: rst clears the word, the pending line and the output register and
//   sets line_width to 32.
// Stall: a stalled receiver holds the current output transfer; the two-entry
//   queue keeps taking input until it fills.
// ----------------------------------------------------------------------------
`default_nettype none

module text_line_justifier (
  input  wire logic  clk,
  input  wire logic  rst,
  tlj_cfg_if.sink    cfg,
  tlj_in_if.sink     text_in,
  tlj_out_if.source  line_out
);

  logic [5:0]                        line_width;
  logic [tlj_pkg::WIDTH_W-1:0]       width;
  logic                              q_push;
  logic                              q_full;
  logic                              q_pop;
  logic                              q_avail;
  tlj_pkg::q_entry_t                 q_data;
  tlj_pkg::q_entry_t                 q_head;

  // width register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst)            line_width <= 6'(tlj_pkg::WIDTH_RESET);
    else if (cfg.valid) line_width <= cfg.line_width;
  end

  // width in effect
  always_comb begin
    if (line_width == '0)                           width = tlj_pkg::WIDTH_W'(1);
    else if (line_width > 6'(tlj_pkg::WIDTH_LIMIT)) width = tlj_pkg::WIDTH_RESET;
    else                                            width = tlj_pkg::WIDTH_W'(line_width);
  end

  tlj_front u_front (
    .clk     (clk),
    .rst     (rst),
    .width   (width),
    .text_in (text_in),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_data)
  );

  tlj_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .avail     (q_avail),
    .head      (q_head)
  );

  tlj_back u_back (
    .clk      (clk),
    .rst      (rst),
    .width    (width),
    .q_avail  (q_avail),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .line_out (line_out)
  );

endmodule

`default_nettype wire

@@ hdl/tlj_checker.sv @@
// ----------------------------------------------------------------------------
// tlj_checker: port-level checks of the text line justifier
// Watches the output channel and the width port over time.
// ----------------------------------------------------------------------------
`default_nettype none

module tlj_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       cfg_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_char,
  input wire logic       line_last,
  input wire logic       run_last
);

  // a stalled output transfer holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_char)
      && $stable(line_last) && $stable(run_last))
    else $error("stalled output changed");

  // the last result of an input always closes a line
  assert property (@(posedge clk) disable iff (rst)
    out_valid && run_last |-> line_last)
    else $error("run_last without line_last");

  // reset empties the output register
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // width port never stalls
  assert property (@(posedge clk) cfg_ready)
    else $error("cfg not ready");

endmodule

bind text_line_justifier tlj_checker u_tlj_checker (
  .clk       (clk),
  .rst       (rst),
  .cfg_ready (cfg.ready),
  .out_valid (line_out.valid),
  .out_ready (line_out.ready),
  .out_char  (line_out.out_char),
  .line_last (line_out.line_last),
  .run_last  (line_out.run_last)
);

`default_nettype wire

@@ tb/tb_text_line_justifier.sv @@
// ----------------------------------------------------------------------------
// tb_text_line_justifier: self-checking testbench of the text line justifier
// Streams words through the block under several line widths and compares
// every emitted character against a built-in justification predictor, with
// random idling on the input and stalls on the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_text_line_justifier;

  localparam int unsigned STORE_WORDS = tlj_pkg::WIDTH_LIMIT / 2;
  localparam int unsigned SETTLE_CYCLES = 120;
  localparam int unsigned IDLE_LIMIT = 5000;
  localparam int unsigned ITEM_TARGET = 220;

  typedef struct {
    logic [7:0] out_char;
    logic       line_last;
    logic       run_last;
  } line_char_t;

  // justification predictor and store of expected characters
  class justify_scoreboard;
    logic [5:0]  width_reg;
    logic [7:0]  line_store [tlj_pkg::WIDTH_LIMIT];
    int unsigned word_lens [STORE_WORDS];
    logic [7:0]  word_store [tlj_pkg::WIDTH_LIMIT];
    int unsigned word_count;
    int unsigned line_used;
    int unsigned word_length;
    line_char_t  expected_chars [$];
    int unsigned mismatches;

    function new();
      width_reg = 6'd32;
      word_count = 0;
      line_used = 0;
      word_length = 0;
      mismatches = 0;
    endfunction

    function void set_width(logic [5:0] w);
      width_reg = w;
    endfunction

    function int unsigned active_width();
      int unsigned w;
      w = width_reg;
      if (w == 0) w = 1;
      if (w > tlj_pkg::WIDTH_LIMIT) w = tlj_pkg::WIDTH_LIMIT;
      return w;
    endfunction

    // push one pending line, fully justified or left-justified
    function void push_line(int unsigned width, bit full);
      logic [7:0]  buffer [tlj_pkg::WIDTH_LIMIT];
      int unsigned cnt, chars, pos, src, each, extra, room;
      line_char_t  c;
      cnt = word_count;
      chars = (line_used >= cnt) ? line_used - cnt : 0;
      pos = 0;
      src = 0;
      each = 1;
      extra = 0;
      if (cnt > STORE_WORDS) cnt = STORE_WORDS;
      for (int i = 0; i < tlj_pkg::WIDTH_LIMIT; i++) buffer[i] = tlj_pkg::SPACE_CHAR;
      if (full && cnt > 1 && chars + (cnt - 1) <= width) begin
        room = width - chars;
        each = room / (cnt - 1);
        extra = room % (cnt - 1);
      end
      for (int k = 0; k < cnt; k++) begin
        for (int i = 0; i < word_lens[k]; i++) begin
          if (pos < width && src < tlj_pkg::WIDTH_LIMIT) buffer[pos] = line_store[src];
          pos++;
          src++;
        end
        pos += each;
        if (extra > 0) begin
          pos++;
          extra--;
        end
      end
      for (int i = 0; i < width; i++) begin
        c.out_char = buffer[i];
        c.line_last = (i + 1 == width);
        c.run_last = 1'b0;
        expected_chars = {expected_chars, c};
      end
      word_count = 0;
      line_used = 0;
    endfunction

    // note one accepted input character
    function void note_input(logic [7:0] ch, logic we, logic te);
      int unsigned width, len, offset, before_cnt;
      width = active_width();
      before_cnt = expected_chars.size();
      if (word_length < width && word_length < tlj_pkg::WIDTH_LIMIT) begin
        word_store[word_length] = ch;
        word_length++;
      end
      if (!we && !te) return;
      len = (word_length > width) ? width : word_length;
      if (word_count > 0 && line_used + len > width) push_line(width, 1'b1);
      offset = (line_used >= word_count) ? line_used - word_count : 0;
      if (word_count < STORE_WORDS && offset + len <= tlj_pkg::WIDTH_LIMIT) begin
        for (int i = 0; i < len; i++) line_store[offset + i] = word_store[i];
        word_lens[word_count] = len;
        word_count++;
        line_used += len + 1;
      end
      word_length = 0;
      if (te) push_line(width, 1'b0);
      if (expected_chars.size() > before_cnt)
        expected_chars[expected_chars.size() - 1].run_last = 1'b1;
    endfunction

    // compare one emitted character with the oldest expectation
    function void check_result(logic [7:0] ch, logic ll, logic rl);
      line_char_t e;
      if (expected_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output char=%02h line_last=%b run_last=%b", ch, ll, rl);
        return;
      end
      e = expected_chars.pop_front();
      if (e.out_char !== ch || e.line_last !== ll || e.run_last !== rl) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected char=%02h ll=%b rl=%b, got char=%02h ll=%b rl=%b",
                   e.out_char, e.line_last, e.run_last, ch, ll, rl);
      end
    endfunction

    function int unsigned pending();
      return expected_chars.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  tlj_cfg_if cfg_ch ();
  tlj_in_if  text_ch ();
  tlj_out_if line_ch ();

  justify_scoreboard sb;
  bit          quiet;
  int unsigned items_sent;
  int unsigned idle_cycles;

  text_line_justifier dut (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg_ch.sink),
    .text_in  (text_ch.sink),
    .line_out (line_ch.source)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // output sink with random stall bursts
  initial begin
    int unsigned stall;
    stall = 0;
    line_ch.ready = 1'b0;
    sb = new();
    forever begin
      @(posedge clk);
      if (!rst && line_ch.valid && line_ch.ready)
        sb.check_result(line_ch.out_char, line_ch.line_last, line_ch.run_last);
      if (rst) begin
        line_ch.ready <= 1'b0;
      end else if (stall > 0 && !quiet) begin
        stall--;
        line_ch.ready <= 1'b0;
      end else begin
        line_ch.ready <= 1'b1;
        if (!quiet && $urandom_range(0, 15) == 0) stall = $urandom_range(1, 19);
      end
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if (rst || (text_ch.valid && text_ch.ready) || (line_ch.valid && line_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // stop sending, then wait until every expected character has come
  task automatic wait_drained();
    text_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_width(logic [5:0] w);
    wait_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.line_width <= w;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.set_width(w);
    cfg_ch.valid <= 1'b0;
  endtask

  // one input transfer, with an optional idle burst ahead of it
  task automatic send_char(logic [7:0] ch, logic we, logic te);
    if (!quiet && $urandom_range(0, 9) == 0) begin
      text_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    text_ch.valid <= 1'b1;
    text_ch.text_char <= ch;
    text_ch.word_end <= we;
    text_ch.text_end <= te;
    do @(posedge clk); while (!text_ch.ready);
    sb.note_input(ch, we, te);
    items_sent++;
  endtask

  task automatic send_word(int unsigned len, bit te);
    for (int i = 0; i < len; i++)
      send_char(8'($urandom_range(0, 255)), i == len - 1, te && (i == len - 1));
  endtask

  initial begin
    logic [5:0]  widths [8];
    int unsigned w, phase;
    rst = 1'b1;
    cfg_ch.valid = 1'b0;
    cfg_ch.line_width = 6'd32;
    text_ch.valid = 1'b0;
    text_ch.text_char = 8'h00;
    text_ch.word_end = 1'b0;
    text_ch.text_end = 1'b0;
    quiet = 1'b0;
    items_sent = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes of the character, overlong word, two lines at once
    write_width(6'd8);
    send_char(8'h00, 1'b1, 1'b0);
    send_word(10, 1'b0);
    send_word(3, 1'b0);
    send_char(8'hff, 1'b0, 1'b0);
    send_char(8'h7f, 1'b0, 1'b0);
    send_char(8'h80, 1'b1, 1'b0);
    send_word(4, 1'b1);
    // width of one, zero acting as one, above range
    write_width(6'd1);
    send_word(2, 1'b1);
    write_width(6'd0);
    send_word(1, 1'b1);
    write_width(6'd63);
    send_word(3, 1'b1);
    // width shrunk with a line pending
    write_width(6'd12);
    send_word(2, 1'b0);
    send_word(2, 1'b0);
    send_word(2, 1'b0);
    write_width(6'd4);
    send_word(2, 1'b1);

    // random phases over several widths
    widths = '{6'd32, 6'd1, 6'd6, 6'd13, 6'd0, 6'd63, 6'd20, 6'd9};
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      write_width((phase == 7) ? 6'($urandom_range(1, 32)) : widths[phase % 8]);
      w = sb.active_width();
      if (items_sent > ITEM_TARGET - 40) quiet = 1'b1;
      repeat (6) begin
        if ($urandom_range(0, 9) == 0)
          send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
        else
          send_word($urandom_range(1, (w > 6 && $urandom_range(0, 3) != 0) ? 6 : w + 2),
                    $urandom_range(0, 5) == 0);
      end
      send_word($urandom_range(1, 4), 1'b1);
      // in phase 3 the sender holds off until every expected character has come
      if (phase == 3) wait_drained();
      phase++;
    end

    wait_drained();
    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/tlj_pkg.sv
hdl/tlj_if.sv
hdl/tlj_queue.sv
hdl/tlj_front.sv
hdl/tlj_back.sv
hdl/text_line_justifier.sv
hdl/tlj_checker.sv
tb/tb_text_line_justifier.sv
